[rtl/core/lfpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lfpd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int READING_W = 10;
    localparam int GAIN_W    = 8;
    localparam int OUT_W     = 12;
    localparam int ERR_W     = 3;
    localparam int DIFF_W    = 4;
    localparam int PROD_W    = 13;

    // magnitude of deriv_gain * error step, at most 1020
    localparam int NUM_W     = 10;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_PROP_GAIN  = 2'd0;
    localparam reg_idx_t REG_DERIV_GAIN = 2'd1;
    localparam reg_idx_t REG_THRESHOLD  = 2'd2;
    localparam reg_idx_t REG_BASE_SPEED = 2'd3;

    localparam logic [READING_W-1:0] THRESHOLD_RESET = 10'd512;

    localparam logic signed [ERR_W-1:0] ERR_FAR_LEFT  = -3'sd2;
    localparam logic signed [ERR_W-1:0] ERR_LEFT      = -3'sd1;
    localparam logic signed [ERR_W-1:0] ERR_CENTRE    = 3'sd0;
    localparam logic signed [ERR_W-1:0] ERR_RIGHT     = 3'sd1;
    localparam logic signed [ERR_W-1:0] ERR_FAR_RIGHT = 3'sd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } lfpd_state_t;

    typedef struct packed {
        logic open;
        logic load;
        logic prep;
        logic step;
        logic finish;
    } lfpd_cmd_t;

    typedef struct packed {
        logic out_busy;
    } lfpd_status_t;

endpackage

`default_nettype wire

[rtl/core/lfpd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfpd_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    input  lfpd_pkg::lfpd_status_t status,
    output lfpd_pkg::lfpd_cmd_t    cmd
);
    import lfpd_pkg::*;

    lfpd_state_t        state_reg;
    lfpd_state_t        state_next;
    logic [STEP_W-1:0]  step_cnt_reg;
    logic [STEP_W-1:0]  step_cnt_next;
    logic               last_step;

    assign last_step = (step_cnt_reg == STEP_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next    = ST_DIV;
                step_cnt_next = '0;
            end
            ST_DIV:
            begin
                if (last_step)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.open = 1'b1;
                cmd.load = in_valid;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            ST_FIN:
            begin
                cmd.finish = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/lfpd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfpd_datapath #(
    parameter int COUNT_WIDTH = lfpd_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  lfpd_pkg::lfpd_cmd_t                        cmd,
    output lfpd_pkg::lfpd_status_t                     status,
    input  wire [lfpd_pkg::GAIN_W-1:0]                 prop_gain,
    input  wire [lfpd_pkg::GAIN_W-1:0]                 deriv_gain,
    input  wire [lfpd_pkg::READING_W-1:0]              tape_threshold,
    input  wire [lfpd_pkg::GAIN_W-1:0]                 base_speed,
    input  wire [lfpd_pkg::READING_W-1:0]              left_reading,
    input  wire [lfpd_pkg::READING_W-1:0]              right_reading,
    input  wire                                       clear_history,
    input  wire                                       out_stall,
    output logic                                      out_valid,
    output logic signed [lfpd_pkg::OUT_W-1:0]          left_drive,
    output logic signed [lfpd_pkg::OUT_W-1:0]          right_drive,
    output logic signed [lfpd_pkg::OUT_W-1:0]          correction
);
    import lfpd_pkg::*;

    localparam int DEN_W = COUNT_WIDTH + 1;

    // captured transaction
    logic [READING_W-1:0]        left_reg;
    logic [READING_W-1:0]        right_reg;
    logic                        clear_reg;

    // error history
    logic signed [ERR_W-1:0]     last_error_reg;
    logic signed [ERR_W-1:0]     saved_error_reg;
    logic [COUNT_WIDTH-1:0]      run_ticks_reg;
    logic [COUNT_WIDTH-1:0]      prior_ticks_reg;

    // divider
    logic [DEN_W-1:0]            den_reg;
    logic [DEN_W-1:0]            rem_reg;
    logic [NUM_W-1:0]            dvd_reg;
    logic                        neg_reg;
    logic signed [OUT_W-1:0]     pterm_reg;

    logic                        out_valid_reg;
    logic signed [OUT_W-1:0]     left_drive_reg;
    logic signed [OUT_W-1:0]     right_drive_reg;
    logic signed [OUT_W-1:0]     correction_reg;

    logic signed [ERR_W-1:0]     last_eff;
    logic signed [ERR_W-1:0]     saved_eff;
    logic                        on_left;
    logic                        on_right;
    logic signed [ERR_W-1:0]     err;
    logic                        changed;
    logic signed [ERR_W-1:0]     saved_mid;
    logic [COUNT_WIDTH-1:0]      prior_mid;
    logic [COUNT_WIDTH-1:0]      run_mid;
    logic [COUNT_WIDTH-1:0]      run_next;
    logic [DEN_W-1:0]            den_sum;
    logic [DEN_W-1:0]            den_eff;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [PROD_W-1:0]    dprod;
    logic signed [PROD_W-1:0]    dprod_abs;
    logic signed [OUT_W-1:0]     pprod;

    logic [DEN_W:0]              rem_shift;
    logic [DEN_W:0]              rem_diff;
    logic                        rem_ge;

    logic signed [OUT_W-1:0]     quot_ext;
    logic signed [OUT_W-1:0]     dterm;
    logic signed [OUT_W-1:0]     corr;
    logic signed [OUT_W-1:0]     base_ext;

    assign last_eff  = clear_reg ? ERR_CENTRE : last_error_reg;
    assign saved_eff = clear_reg ? ERR_CENTRE : saved_error_reg;
    assign on_left   = left_reg > tape_threshold;
    assign on_right  = right_reg > tape_threshold;

    always_comb
    begin
        if (on_left && on_right)
        begin
            err = ERR_CENTRE;
        end
        else if (on_left)
        begin
            err = ERR_LEFT;
        end
        else if (on_right)
        begin
            err = ERR_RIGHT;
        end
        else if (last_eff < ERR_CENTRE)
        begin
            err = ERR_FAR_LEFT;
        end
        else
        begin
            err = ERR_FAR_RIGHT;
        end
    end

    assign changed   = (err != last_eff);
    assign saved_mid = changed ? last_eff : saved_eff;
    assign prior_mid = changed ? run_ticks_reg : prior_ticks_reg;
    assign run_mid   = changed ? COUNT_WIDTH'(1) : run_ticks_reg;
    assign run_next  = (run_mid != {COUNT_WIDTH{1'b1}}) ? run_mid + COUNT_WIDTH'(1) : run_mid;
    assign den_sum   = {1'b0, prior_mid} + {1'b0, run_mid};
    assign den_eff   = (den_sum == '0) ? DEN_W'(1) : den_sum;

    assign diff  = {err[ERR_W-1], err} - {saved_mid[ERR_W-1], saved_mid};
    assign dprod = $signed({5'b0, deriv_gain})
                 * $signed({{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff});
    assign dprod_abs = dprod[PROD_W-1] ? -dprod : dprod;
    assign pprod = $signed({4'b0, prop_gain})
                 * $signed({{(OUT_W-ERR_W){err[ERR_W-1]}}, err});

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg, dvd_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    assign quot_ext = $signed({{(OUT_W-NUM_W){1'b0}}, dvd_reg});
    assign dterm    = neg_reg ? -quot_ext : quot_ext;
    assign corr     = pterm_reg + dterm;
    assign base_ext = $signed({4'b0, base_speed});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg  <= ERR_CENTRE;
            saved_error_reg <= ERR_CENTRE;
            run_ticks_reg   <= '0;
            prior_ticks_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.prep)
            begin
                last_error_reg  <= err;
                saved_error_reg <= saved_mid;
                run_ticks_reg   <= run_next;
                prior_ticks_reg <= prior_mid;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            left_reg  <= left_reading;
            right_reg <= right_reading;
            clear_reg <= clear_history;
        end
        if (cmd.prep)
        begin
            den_reg   <= den_eff;
            rem_reg   <= '0;
            dvd_reg   <= dprod_abs[NUM_W-1:0];
            neg_reg   <= dprod[PROD_W-1];
            pterm_reg <= pprod;
        end
        if (cmd.step)
        begin
            rem_reg <= rem_ge ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            dvd_reg <= {dvd_reg[NUM_W-2:0], rem_ge};
        end
        if (cmd.finish)
        begin
            correction_reg  <= corr;
            left_drive_reg  <= corr - base_ext;
            right_drive_reg <= corr + base_ext;
        end
    end

    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign left_drive      = left_drive_reg;
    assign right_drive     = right_drive_reg;
    assign correction      = correction_reg;

endmodule

`default_nettype wire

[rtl/core/line_follow_pd_controller.sv]
// channel    direction   handshake           payload
// input      in          in_valid/in_stall   left_reading, right_reading, clear_history
// output     out         out_valid/out_stall left_drive, right_drive, correction
// config     in          apb write/read      prop_gain, deriv_gain, tape_threshold, base_speed
//
// a transaction passes through capture, error and history update, the
// bit-serial divider for the derivative term, and result load
// rst_n clears the error history, run counters, config registers (threshold to 512) and output valid
// a finished result waits in the output register while the next transaction
// is taken; the result load waits only if that register is still stalled
`timescale 1ns / 1ps
`default_nettype none

module line_follow_pd_controller #(
    parameter int COUNT_WIDTH = lfpd_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  wire                                       psel,
    input  wire                                       penable,
    input  wire                                       pwrite,
    input  wire [lfpd_pkg::PADDR_W-1:0]                paddr,
    input  wire [lfpd_pkg::PDATA_W-1:0]                pwdata,
    output logic [lfpd_pkg::PDATA_W-1:0]               prdata,
    output logic                                      pready,
    input  wire                                       in_valid,
    output logic                                      in_stall,
    input  wire [lfpd_pkg::READING_W-1:0]              left_reading,
    input  wire [lfpd_pkg::READING_W-1:0]              right_reading,
    input  wire                                       clear_history,
    output logic                                      out_valid,
    input  wire                                       out_stall,
    output logic signed [lfpd_pkg::OUT_W-1:0]          left_drive,
    output logic signed [lfpd_pkg::OUT_W-1:0]          right_drive,
    output logic signed [lfpd_pkg::OUT_W-1:0]          correction
);
    import lfpd_pkg::*;

    logic [GAIN_W-1:0]     prop_gain_reg;
    logic [GAIN_W-1:0]     deriv_gain_reg;
    logic [READING_W-1:0]  threshold_reg;
    logic [GAIN_W-1:0]     base_speed_reg;
    logic                  cfg_write;
    reg_idx_t              cfg_idx;
    lfpd_cmd_t             cmd;
    lfpd_status_t          status;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= '0;
            deriv_gain_reg <= '0;
            threshold_reg  <= THRESHOLD_RESET;
            base_speed_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_PROP_GAIN:  prop_gain_reg  <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN: deriv_gain_reg <= pwdata[GAIN_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= pwdata[READING_W-1:0];
                REG_BASE_SPEED: base_speed_reg <= pwdata[GAIN_W-1:0];
                default:        prop_gain_reg  <= prop_gain_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PROP_GAIN:  prdata = PDATA_W'(prop_gain_reg);
            REG_DERIV_GAIN: prdata = PDATA_W'(deriv_gain_reg);
            REG_THRESHOLD:  prdata = PDATA_W'(threshold_reg);
            REG_BASE_SPEED: prdata = PDATA_W'(base_speed_reg);
            default:        prdata = '0;
        endcase
    end

    assign in_stall = !cmd.open;

    lfpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd)
    );

    lfpd_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .prop_gain      (prop_gain_reg),
        .deriv_gain     (deriv_gain_reg),
        .tape_threshold (threshold_reg),
        .base_speed     (base_speed_reg),
        .left_reading   (left_reading),
        .right_reading  (right_reading),
        .clear_history  (clear_history),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .left_drive     (left_drive),
        .right_drive    (right_drive),
        .correction     (correction)
    );

endmodule

`default_nettype wire
